### src/lfc_pkg.sv
// Shared types, constants and the segment lookup for the two-channel lux core.
`default_nettype none

package lfc_pkg;

   // Field widths
   localparam int CNT_W     = 16;   // raw photodiode count
   localparam int BASE_W    = 15;   // Q10 time scale before the gain shift
   localparam int GAIN_SH   = 4;    // 1x gain scales by 16
   localparam int SCL_W     = BASE_W + GAIN_SH;
   localparam int CH_FRAC   = 10;
   localparam int CH_W      = CNT_W + SCL_W - CH_FRAC;  // scaled count
   localparam int QUO_W     = 11;   // Q10 ratio, limited to below 2.0
   localparam int DIV_STEPS = QUO_W - 1;
   localparam int COEF_W    = 10;
   localparam int PROD_W    = CH_W + COEF_W;
   localparam int LUX_FRAC  = 14;
   localparam int LUX_W     = 21;
   localparam int SEGMENTS  = 8;

   // Configuration port
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_IDX_MODE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_IDX_GAIN = 1'b1;

   // Integration time codes
   localparam logic [1:0] MODE_13MS  = 2'd0;
   localparam logic [1:0] MODE_101MS = 2'd1;
   localparam logic [1:0] MODE_402MS = 2'd2;

   // Q10 scale factors
   localparam logic [BASE_W-1:0] SCALE_13MS  = 15'h7517;
   localparam logic [BASE_W-1:0] SCALE_101MS = 15'h0FE7;
   localparam logic [BASE_W-1:0] SCALE_UNITY = 15'h0400;

   // Rounding constant for the Q14 result
   localparam logic [PROD_W:0] LUX_HALF = (PROD_W + 1)'(1 << (LUX_FRAC - 1));

   // CS-package breakpoints (Q9 ratio), intercepts and slopes
   localparam logic [QUO_W-1:0] SEG_LIMIT [SEGMENTS] = '{
      11'h043, 11'h085, 11'h0C8, 11'h10A, 11'h14D, 11'h19A, 11'h29A, 11'h29A
   };
   localparam logic [COEF_W-1:0] SEG_B [SEGMENTS] = '{
      10'h204, 10'h228, 10'h253, 10'h282, 10'h177, 10'h101, 10'h037, 10'h000
   };
   localparam logic [COEF_W-1:0] SEG_M [SEGMENTS] = '{
      10'h1AD, 10'h2C1, 10'h363, 10'h3DF, 10'h1DD, 10'h127, 10'h02B, 10'h000
   };

   typedef struct packed {
      logic [1:0] integration_mode;
      logic       high_gain;
   } lfc_cfg_type;

   // Scaled count pair leaving the multiplier stage
   typedef struct packed {
      logic            valid;
      logic [CH_W-1:0] c0;
      logic [CH_W-1:0] c1;
   } lfc_counts_type;

   // One divider stage
   typedef struct packed {
      logic             valid;
      logic             zero;   // broadband scaled to zero
      logic             over;   // ratio of 2.0 or more, beyond every segment
      logic [QUO_W-1:0] quo;
      logic [CH_W-1:0]  rem;
      logic [CH_W-1:0]  c0;
      logic [CH_W-1:0]  c1;
   } lfc_div_stage_type;

   // Ratio handed to the lux stages
   typedef struct packed {
      logic             valid;
      logic             zero;
      logic             over;
      logic [QUO_W-1:0] quo;
      logic [CH_W-1:0]  c0;
      logic [CH_W-1:0]  c1;
   } lfc_ratio_type;

   typedef struct packed {
      logic [COEF_W-1:0] b;
      logic [COEF_W-1:0] m;
   } lfc_coef_type;

   // First segment whose limit the rounded Q9 ratio does not exceed
   function automatic lfc_coef_type lfc_segment(input logic [QUO_W-1:0] ratio);
      lfc_coef_type coef;
      logic         found;
      coef  = '0;
      found = 1'b0;
      for (int k = 0; k < SEGMENTS; k++) begin
         if (!found && ratio <= SEG_LIMIT[k]) begin
            coef.b = SEG_B[k];
            coef.m = SEG_M[k];
            found  = 1'b1;
         end
      end
      return coef;
   endfunction

endpackage

`default_nettype wire

### src/lfc_scale.sv
// Input stage: scales both raw counts by integration time and gain.
`default_nettype none

module lfc_scale (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         in_valid,
   input  wire logic [lfc_pkg::CNT_W-1:0]    broadband_count,
   input  wire logic [lfc_pkg::CNT_W-1:0]    infrared_count,
   input  wire lfc_pkg::lfc_cfg_type         cfg,
   output lfc_pkg::lfc_counts_type           counts
);
   import lfc_pkg::*;

   logic [BASE_W-1:0]       base;
   logic [SCL_W-1:0]        scale;
   logic [CNT_W+SCL_W-1:0]  prod0;
   logic [CNT_W+SCL_W-1:0]  prod1;
   lfc_counts_type          counts_in;
   lfc_counts_type          counts_ff;

   // Scale factor from the configuration; 402 ms and the unused mode code take the unity time scale
   always_comb begin
      priority if (cfg.integration_mode == MODE_13MS) begin
         base = SCALE_13MS;
      end else if (cfg.integration_mode == MODE_101MS) begin
         base = SCALE_101MS;
      end else begin
         base = SCALE_UNITY;
      end
      scale = cfg.high_gain ? {{GAIN_SH{1'b0}}, base} : {base, {GAIN_SH{1'b0}}};
   end

   // Two parallel multipliers, Q10 dropped
   always_comb begin
      prod0            = {{SCL_W{1'b0}}, broadband_count} * {{CNT_W{1'b0}}, scale};
      prod1            = {{SCL_W{1'b0}}, infrared_count} * {{CNT_W{1'b0}}, scale};
      counts_in.valid  = in_valid;
      counts_in.c0     = prod0[CNT_W+SCL_W-1:CH_FRAC];
      counts_in.c1     = prod1[CNT_W+SCL_W-1:CH_FRAC];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         counts_ff.valid <= 1'b0;
      end else begin
         counts_ff.valid <= counts_in.valid;
      end
      counts_ff.c0 <= counts_in.c0;
      counts_ff.c1 <= counts_in.c1;
   end

   assign counts = counts_ff;

endmodule

`default_nettype wire

### src/lfc_div.sv
// Pipelined restoring divider: Q10 ratio of infrared to broadband, one bit a stage.
`default_nettype none

module lfc_div (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire lfc_pkg::lfc_counts_type  counts,
   output lfc_pkg::lfc_ratio_type        ratio
);
   import lfc_pkg::*;

   lfc_div_stage_type stage_in [DIV_STEPS+1];
   lfc_div_stage_type stage_ff [DIV_STEPS+1];

   // First stage: range check and the integer bit of the quotient
   always_comb begin
      logic ge0;
      ge0               = counts.c1 >= counts.c0;
      stage_in[0].valid = counts.valid;
      stage_in[0].zero  = counts.c0 == '0;
      stage_in[0].over  = {1'b0, counts.c1} >= {counts.c0, 1'b0};
      stage_in[0].quo   = {{(QUO_W-1){1'b0}}, ge0};
      stage_in[0].rem   = ge0 ? counts.c1 - counts.c0 : counts.c1;
      stage_in[0].c0    = counts.c0;
      stage_in[0].c1    = counts.c1;
   end

   // Fraction bits: shift, compare, subtract
   for (genvar g = 1; g <= DIV_STEPS; g++) begin : g_step
      logic [CH_W:0] rem2;
      logic [CH_W:0] diff;
      logic          ge;

      always_comb begin
         rem2           = {stage_ff[g-1].rem, 1'b0};
         diff           = rem2 - {1'b0, stage_ff[g-1].c0};
         ge             = rem2 >= {1'b0, stage_ff[g-1].c0};
         stage_in[g]     = stage_ff[g-1];
         stage_in[g].quo = {stage_ff[g-1].quo[QUO_W-2:0], ge};
         stage_in[g].rem = ge ? diff[CH_W-1:0] : rem2[CH_W-1:0];
      end
   end

   // Stage registers; only the valid bits are reset
   for (genvar s = 0; s <= DIV_STEPS; s++) begin : g_reg
      always_ff @(posedge clock) begin
         if (reset) begin
            stage_ff[s].valid <= 1'b0;
         end else begin
            stage_ff[s].valid <= stage_in[s].valid;
         end
         stage_ff[s].zero <= stage_in[s].zero;
         stage_ff[s].over <= stage_in[s].over;
         stage_ff[s].quo  <= stage_in[s].quo;
         stage_ff[s].rem  <= stage_in[s].rem;
         stage_ff[s].c0   <= stage_in[s].c0;
         stage_ff[s].c1   <= stage_in[s].c1;
      end
   end

   always_comb begin
      ratio.valid = stage_ff[DIV_STEPS].valid;
      ratio.zero  = stage_ff[DIV_STEPS].zero;
      ratio.over  = stage_ff[DIV_STEPS].over;
      ratio.quo   = stage_ff[DIV_STEPS].quo;
      ratio.c0    = stage_ff[DIV_STEPS].c0;
      ratio.c1    = stage_ff[DIV_STEPS].c1;
   end

`ifndef NO_ASSERTIONS
   // Remainder stays below the divisor whenever the quotient is in range
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      stage_ff[DIV_STEPS].valid && !stage_ff[DIV_STEPS].zero && !stage_ff[DIV_STEPS].over
      |-> stage_ff[DIV_STEPS].rem < stage_ff[DIV_STEPS].c0)
      else $error("divider remainder not below divisor");

   // Each transaction leaves the divider only after passing through every stage register
   a_div_latency: assert property (@(posedge clock) disable iff (reset)
      stage_ff[DIV_STEPS].valid |-> $past(counts.valid, DIV_STEPS + 1))
      else $error("divider output without matching input");
`endif

endmodule

`default_nettype wire

### src/lfc_lux.sv
// Back end: segment lookup, weighted products, clamp, round and output register.
`default_nettype none

module lfc_lux (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire lfc_pkg::lfc_ratio_type  ratio,
   output logic                         rsp_valid,
   output logic [lfc_pkg::LUX_W-1:0]    rsp_lux
);
   import lfc_pkg::*;

   // Segment stage
   logic [QUO_W:0]     ratio_sum;
   logic [QUO_W-1:0]   ratio_rnd;
   lfc_coef_type       coef;
   logic               seg_valid_ff;
   logic [CH_W-1:0]    seg_c0_ff;
   logic [CH_W-1:0]    seg_c1_ff;
   lfc_coef_type       seg_coef_ff;

   // Multiply stage
   logic               mul_valid_ff;
   logic [PROD_W-1:0]  pos_in;
   logic [PROD_W-1:0]  neg_in;
   logic [PROD_W-1:0]  pos_ff;
   logic [PROD_W-1:0]  neg_ff;

   // Output stage
   logic [PROD_W:0]          rounded;
   logic [PROD_W-LUX_FRAC:0] shifted;
   logic [LUX_W-1:0]         lux_in;
   logic                     rsp_valid_ff;
   logic [LUX_W-1:0]         rsp_lux_ff;

   // Round Q10 ratio to Q9 and pick the segment; zero broadband reads as ratio 0
   always_comb begin
      ratio_sum = {1'b0, ratio.quo} + (QUO_W + 1)'(1);
      ratio_rnd = ratio.zero ? '0 : ratio_sum[QUO_W:1];
      coef      = ratio.over ? '0 : lfc_segment(ratio_rnd);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_valid_ff <= 1'b0;
      end else begin
         seg_valid_ff <= ratio.valid;
      end
      seg_c0_ff   <= ratio.c0;
      seg_c1_ff   <= ratio.c1;
      seg_coef_ff <= coef;
   end

   // Channel products
   always_comb begin
      pos_in = {{COEF_W{1'b0}}, seg_c0_ff} * {{CH_W{1'b0}}, seg_coef_ff.b};
      neg_in = {{COEF_W{1'b0}}, seg_c1_ff} * {{CH_W{1'b0}}, seg_coef_ff.m};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
      end else begin
         mul_valid_ff <= seg_valid_ff;
      end
      pos_ff <= pos_in;
      neg_ff <= neg_in;
   end

   // Difference with half-lux rounding, negative clamps to zero, saturate at full scale
   always_comb begin
      rounded = {1'b0, pos_ff} + LUX_HALF - {1'b0, neg_ff};
      shifted = rounded[PROD_W:LUX_FRAC];
      if (pos_ff <= neg_ff) begin
         lux_in = '0;
      end else if (shifted > {1'b0, {LUX_W{1'b1}}}) begin
         lux_in = {LUX_W{1'b1}};
      end else begin
         lux_in = shifted[LUX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= mul_valid_ff;
      end
      rsp_lux_ff <= lux_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_lux   = rsp_lux_ff;

`ifndef NO_ASSERTIONS
   // A zero intercept can only give zero lux once it reaches the output register
   a_zero_b: assert property (@(posedge clock) disable iff (reset)
      seg_valid_ff && seg_coef_ff.b == '0 |-> ##2 (rsp_valid && rsp_lux == '0))
      else $error("zero intercept gave non-zero lux");

   // Beyond the last breakpoint both coefficients are cleared
   a_over_coef: assert property (@(posedge clock) disable iff (reset)
      ratio.valid && ratio.over |=> seg_coef_ff.b == '0 && seg_coef_ff.m == '0)
      else $error("out-of-range ratio picked a segment");
`endif

endmodule

`default_nettype wire

### src/lux_from_two_channel_counts_core.sv
// Top level: configuration registers and the lux pipeline.
// A result strobes on rsp_valid after the scale, divider stage, segment, multiply and output registers.
// Throughput: one transaction per cycle; busy stays low, the 11-stage divider sets the depth.
// The receiver cannot stall: every result is shown for exactly one cycle.
// Reset (synchronous) empties the pipeline and sets 402 ms integration and 16x gain.
`default_nettype none

module lux_from_two_channel_counts_core (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [lfc_pkg::CNT_W-1:0]     req_broadband_count,
   input  wire logic [lfc_pkg::CNT_W-1:0]     req_infrared_count,
   output logic                               rsp_valid,
   output logic [lfc_pkg::LUX_W-1:0]          rsp_lux,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [lfc_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [lfc_pkg::CSR_DATA_W-1:0] csr_data
);
   import lfc_pkg::*;

   lfc_cfg_type    cfg_ff;
   lfc_counts_type counts;
   lfc_ratio_type  ratio;
   logic           in_valid;

   // Fully pipelined: always ready for a transaction and a register write
   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign in_valid  = start && !busy;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.integration_mode <= MODE_402MS;
         cfg_ff.high_gain        <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_IDX_MODE: begin
               cfg_ff.integration_mode <= csr_data[1:0];
            end
            CSR_IDX_GAIN: begin
               cfg_ff.high_gain <= csr_data[0];
            end
         endcase
      end
   end

   lfc_scale u_scale (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (in_valid),
      .broadband_count (req_broadband_count),
      .infrared_count  (req_infrared_count),
      .cfg             (cfg_ff),
      .counts          (counts)
   );

   lfc_div u_div (
      .clock  (clock),
      .reset  (reset),
      .counts (counts),
      .ratio  (ratio)
   );

   lfc_lux u_lux (
      .clock     (clock),
      .reset     (reset),
      .ratio     (ratio),
      .rsp_valid (rsp_valid),
      .rsp_lux   (rsp_lux)
   );

endmodule

`default_nettype wire
